@@ rtl/core/hpack_huffman_encoder_macros.svh @@
// Assertion macros for the HPACK Huffman encoder checker.
// Used by hpack_chk; needs clk and rst_n in scope.
`ifndef HPACK_HUFFMAN_ENCODER_MACROS_SVH
`define HPACK_HUFFMAN_ENCODER_MACROS_SVH
`define HPACK_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("hpack check failed");
`define HPACK_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("hpack check failed");
`endif

@@ rtl/core/hpack_pkg.sv @@
// Package for the HPACK Huffman encoder: request types and code tables.
// No dependencies.
package hpack_pkg;

  typedef struct packed {
    logic [7:0] symbol_byte;
    logic       last_symbol;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
    logic       status;
  } out_req_t;

  localparam int unsigned MaxBytes = 5;
  localparam logic [15:0] CapReset = 16'hFFFF;

  localparam logic [29:0] CODE_TAB [256] = '{
    30'h1ff8,30'h7fffd8,30'hfffffe2,30'hfffffe3,30'hfffffe4,30'hfffffe5,30'hfffffe6,30'hfffffe7,
    30'hfffffe8,30'hffffea,30'h3ffffffc,30'hfffffe9,30'hfffffea,30'h3ffffffd,30'hfffffeb,
    30'hfffffec,
    30'hfffffed,30'hfffffee,30'hfffffef,30'hffffff0,30'hffffff1,30'hffffff2,30'h3ffffffe,
    30'hffffff3,
    30'hffffff4,30'hffffff5,30'hffffff6,30'hffffff7,30'hffffff8,30'hffffff9,30'hffffffa,
    30'hffffffb,
    30'h14,30'h3f8,30'h3f9,30'hffa,30'h1ff9,30'h15,30'hf8,30'h7fa,
    30'h3fa,30'h3fb,30'hf9,30'h7fb,30'hfa,30'h16,30'h17,30'h18,
    30'h0,30'h1,30'h2,30'h19,30'h1a,30'h1b,30'h1c,30'h1d,
    30'h1e,30'h1f,30'h5c,30'hfb,30'h7ffc,30'h20,30'hffb,30'h3fc,
    30'h1ffa,30'h21,30'h5d,30'h5e,30'h5f,30'h60,30'h61,30'h62,
    30'h63,30'h64,30'h65,30'h66,30'h67,30'h68,30'h69,30'h6a,
    30'h6b,30'h6c,30'h6d,30'h6e,30'h6f,30'h70,30'h71,30'h72,
    30'hfc,30'h73,30'hfd,30'h1ffb,30'h7fff0,30'h1ffc,30'h3ffc,30'h22,
    30'h7ffd,30'h3,30'h23,30'h4,30'h24,30'h5,30'h25,30'h26,
    30'h27,30'h6,30'h74,30'h75,30'h28,30'h29,30'h2a,30'h7,
    30'h2b,30'h76,30'h2c,30'h8,30'h9,30'h2d,30'h77,30'h78,
    30'h79,30'h7a,30'h7b,30'h7ffe,30'h7fc,30'h3ffd,30'h1ffd,30'hffffffc,
    30'hfffe6,30'h3fffd2,30'hfffe7,30'hfffe8,30'h3fffd3,30'h3fffd4,30'h3fffd5,30'h7fffd9,
    30'h3fffd6,30'h7fffda,30'h7fffdb,30'h7fffdc,30'h7fffdd,30'h7fffde,30'hffffeb,30'h7fffdf,
    30'hffffec,30'hffffed,30'h3fffd7,30'h7fffe0,30'hffffee,30'h7fffe1,30'h7fffe2,30'h7fffe3,
    30'h7fffe4,30'h1fffdc,30'h3fffd8,30'h7fffe5,30'h3fffd9,30'h7fffe6,30'h7fffe7,30'hffffef,
    30'h3fffda,30'h1fffdd,30'hfffe9,30'h3fffdb,30'h3fffdc,30'h7fffe8,30'h7fffe9,30'h1fffde,
    30'h7fffea,30'h3fffdd,30'h3fffde,30'hfffff0,30'h1fffdf,30'h3fffdf,30'h7fffeb,30'h7fffec,
    30'h1fffe0,30'h1fffe1,30'h3fffe0,30'h1fffe2,30'h7fffed,30'h3fffe1,30'h7fffee,30'h7fffef,
    30'hfffea,30'h3fffe2,30'h3fffe3,30'h3fffe4,30'h7ffff0,30'h3fffe5,30'h3fffe6,30'h7ffff1,
    30'h3ffffe0,30'h3ffffe1,30'hfffeb,30'h7fff1,30'h3fffe7,30'h7ffff2,30'h3fffe8,30'h1ffffec,
    30'h3ffffe2,30'h3ffffe3,30'h3ffffe4,30'h7ffffde,30'h7ffffdf,30'h3ffffe5,30'hfffff1,
    30'h1ffffed,
    30'h7fff2,30'h1fffe3,30'h3ffffe6,30'h7ffffe0,30'h7ffffe1,30'h3ffffe7,30'h7ffffe2,30'hfffff2,
    30'h1fffe4,30'h1fffe5,30'h3ffffe8,30'h3ffffe9,30'hffffffd,30'h7ffffe3,30'h7ffffe4,
    30'h7ffffe5,
    30'hfffec,30'hfffff3,30'hfffed,30'h1fffe6,30'h3fffe9,30'h1fffe7,30'h1fffe8,30'h7ffff3,
    30'h3fffea,30'h3fffeb,30'h1ffffee,30'h1ffffef,30'hfffff4,30'hfffff5,30'h3ffffea,30'h7ffff4,
    30'h3ffffeb,30'h7ffffe6,30'h3ffffec,30'h3ffffed,30'h7ffffe7,30'h7ffffe8,30'h7ffffe9,
    30'h7ffffea,
    30'h7ffffeb,30'hffffffe,30'h7ffffec,30'h7ffffed,30'h7ffffee,30'h7ffffef,30'h7fffff0,
    30'h3ffffee
  };

  localparam logic [4:0] LEN_TAB [256] = '{
    5'd13,5'd23,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,
    5'd28,5'd24,5'd30,5'd28,5'd28,5'd30,5'd28,5'd28,
    5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd30,5'd28,
    5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,
    5'd6,5'd10,5'd10,5'd12,5'd13,5'd6,5'd8,5'd11,
    5'd10,5'd10,5'd8,5'd11,5'd8,5'd6,5'd6,5'd6,
    5'd5,5'd5,5'd5,5'd6,5'd6,5'd6,5'd6,5'd6,
    5'd6,5'd6,5'd7,5'd8,5'd15,5'd6,5'd12,5'd10,
    5'd13,5'd6,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,
    5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,
    5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,
    5'd8,5'd7,5'd8,5'd13,5'd19,5'd13,5'd14,5'd6,
    5'd15,5'd5,5'd6,5'd5,5'd6,5'd5,5'd6,5'd6,
    5'd6,5'd5,5'd7,5'd7,5'd6,5'd6,5'd6,5'd5,
    5'd6,5'd7,5'd6,5'd5,5'd5,5'd6,5'd7,5'd7,
    5'd7,5'd7,5'd7,5'd15,5'd11,5'd14,5'd13,5'd28,
    5'd20,5'd22,5'd20,5'd20,5'd22,5'd22,5'd22,5'd23,
    5'd22,5'd23,5'd23,5'd23,5'd23,5'd23,5'd24,5'd23,
    5'd24,5'd24,5'd22,5'd23,5'd24,5'd23,5'd23,5'd23,
    5'd23,5'd21,5'd22,5'd23,5'd22,5'd23,5'd23,5'd24,
    5'd22,5'd21,5'd20,5'd22,5'd22,5'd23,5'd23,5'd21,
    5'd23,5'd22,5'd22,5'd24,5'd21,5'd22,5'd23,5'd23,
    5'd21,5'd21,5'd22,5'd21,5'd23,5'd22,5'd23,5'd23,
    5'd20,5'd22,5'd22,5'd22,5'd23,5'd22,5'd22,5'd23,
    5'd26,5'd26,5'd20,5'd19,5'd22,5'd23,5'd22,5'd25,
    5'd26,5'd26,5'd26,5'd27,5'd27,5'd26,5'd24,5'd25,
    5'd19,5'd21,5'd26,5'd27,5'd27,5'd26,5'd27,5'd24,
    5'd21,5'd21,5'd26,5'd26,5'd28,5'd27,5'd27,5'd27,
    5'd20,5'd24,5'd20,5'd21,5'd22,5'd21,5'd21,5'd23,
    5'd22,5'd22,5'd25,5'd25,5'd24,5'd24,5'd26,5'd23,
    5'd26,5'd27,5'd26,5'd26,5'd27,5'd27,5'd27,5'd27,
    5'd27,5'd28,5'd27,5'd27,5'd27,5'd27,5'd27,5'd26
  };

endpackage

@@ rtl/core/hpack_huffman_encoder.sv @@
// HPACK Huffman encoder top level: code lookup, bit packing, output buffer.
// Depends on hpack_pkg.
// One string byte is taken per cycle unless in_stall; its code is packed and
// the finished octets (up to five) are loaded into an output buffer that
// hands out one octet per cycle unless out_stall. A byte that completes at
// most one octet stalls the input only under out_stall; a byte that completes
// more holds it while the buffer drains. cfg_wdata sets the octet capacity per string.
module hpack_huffman_encoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  hpack_pkg::in_req_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hpack_pkg::out_req_t out_data
);
  import hpack_pkg::*;

  logic [15:0] cap_r;
  logic [6:0]  pend_bits_r, pend_bits_nxt;
  logic [2:0]  pend_cnt_r, pend_cnt_nxt;
  logic [15:0] bytes_r, bytes_nxt;
  logic        err_r, err_nxt;

  logic [7:0]  buf_r [MaxBytes];
  logic [7:0]  buf_nxt [MaxBytes];
  logic [2:0]  cnt_r, cnt_nxt;
  logic        last_r, last_nxt;
  logic        stat_r, stat_nxt;

  logic        in_acc, out_take;
  logic [29:0] code;
  logic [4:0]  len;
  logic [36:0] acc;
  logic [5:0]  n;
  logic [2:0]  full;
  logic        part;
  logic [16:0] need;
  logic        ovf;
  logic [39:0] left, packed_w;

  assign in_stall = (cnt_r > 3'd1) || (cnt_r == 3'd1 && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = (cnt_r != 3'd0);
  assign out_take  = out_valid && !out_stall;

  assign out_data.out_byte  = buf_r[0];
  assign out_data.last_byte = last_r && (cnt_r == 3'd1);
  assign out_data.status    = stat_r;

  always_comb begin
    code = CODE_TAB[in_data.symbol_byte];
    len  = LEN_TAB[in_data.symbol_byte];
    acc  = ({30'd0, pend_bits_r} << len) | {7'd0, code};
    n    = {3'd0, pend_cnt_r} + {1'b0, len};
    full = n[5:3];
    part = |n[2:0];
    need = {1'b0, bytes_r} + {14'd0, full} + {16'd0, part};
    ovf  = need > {1'b0, cap_r};
    left = {3'd0, acc} << (6'd40 - n);
    packed_w = left | (in_data.last_symbol ? (40'hFF_FFFF_FFFF >> n) : 40'd0);
  end

  always_comb begin
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    bytes_nxt     = bytes_r;
    err_nxt       = err_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    stat_nxt      = stat_r;
    for (int i = 0; i < MaxBytes; i++) begin
      buf_nxt[i] = (i < MaxBytes - 1) ? buf_r[(i + 1) % MaxBytes] : buf_r[i];
    end
    if (out_take) begin
      cnt_nxt = cnt_r - 3'd1;
    end else begin
      for (int i = 0; i < MaxBytes; i++) buf_nxt[i] = buf_r[i];
    end
    if (in_acc) begin
      if (err_r) begin
        if (in_data.last_symbol) begin
          buf_nxt[0] = 8'd0;
          cnt_nxt    = 3'd1;
          last_nxt   = 1'b1;
          stat_nxt   = 1'b1;
          pend_bits_nxt = 7'd0;
          pend_cnt_nxt  = 3'd0;
          bytes_nxt     = 16'd0;
          err_nxt       = 1'b0;
        end
      end else if (ovf) begin
        buf_nxt[0] = 8'd0;
        cnt_nxt    = 3'd1;
        last_nxt   = in_data.last_symbol;
        stat_nxt   = 1'b1;
        if (in_data.last_symbol) begin
          pend_bits_nxt = 7'd0;
          pend_cnt_nxt  = 3'd0;
          bytes_nxt     = 16'd0;
        end else begin
          err_nxt = 1'b1;
        end
      end else begin
        for (int i = 0; i < MaxBytes; i++) begin
          buf_nxt[i] = packed_w[39 - 8 * i -: 8];
        end
        last_nxt = in_data.last_symbol;
        stat_nxt = 1'b0;
        if (in_data.last_symbol) begin
          cnt_nxt       = full + {2'd0, part};
          pend_bits_nxt = 7'd0;
          pend_cnt_nxt  = 3'd0;
          bytes_nxt     = 16'd0;
        end else begin
          if (full != 3'd0) cnt_nxt = full;
          pend_cnt_nxt  = n[2:0];
          pend_bits_nxt = acc[6:0] & ((7'd1 << n[2:0]) - 7'd1);
          bytes_nxt     = bytes_r + {13'd0, full};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CapReset;
      pend_bits_r <= 7'd0;
      pend_cnt_r  <= 3'd0;
      bytes_r     <= 16'd0;
      err_r       <= 1'b0;
      cnt_r       <= 3'd0;
      last_r      <= 1'b0;
      stat_r      <= 1'b0;
    end else begin
      if (cfg_we) cap_r <= cfg_wdata;
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      bytes_r     <= bytes_nxt;
      err_r       <= err_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      stat_r      <= stat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MaxBytes; i++) buf_r[i] <= buf_nxt[i];
  end

endmodule

@@ rtl/core/hpack_chk.sv @@
// Port checker for the HPACK Huffman encoder, bound to the top level.
// Depends on hpack_pkg and hpack_huffman_encoder_macros.svh.
`include "hpack_huffman_encoder_macros.svh"
module hpack_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input hpack_pkg::out_req_t out_data
);
  import hpack_pkg::*;

  `HPACK_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `HPACK_ASSERT_IMP(a_err_zero, out_valid && out_data.status, out_data.out_byte == 8'd0)
  `HPACK_ASSERT_IMP(a_stall_out, in_stall, out_valid)
  `HPACK_ASSERT_NXT(a_in_hold, in_valid && in_stall, in_valid)
endmodule

bind hpack_huffman_encoder hpack_chk u_hpack_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
